/* rtl/ext4_address_to_inode_number_top_assert.svh */
// Assertion macros shared by the inode number mapper RTL.
// Needs nothing else; define NO_ASSERTIONS to compile them away.
`ifndef EXT4_ADDRESS_TO_INODE_NUMBER_TOP_ASSERT_SVH
`define EXT4_ADDRESS_TO_INODE_NUMBER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define E4AIN_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define E4AIN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define E4AIN_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define E4AIN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/e4ain_pkg.sv */
// Constants and helpers for the inode number mapper.
// Used by ext4_address_to_inode_number_top; depends on nothing.
package e4ain_pkg;
	localparam int unsigned BsW    = 17;
	localparam int unsigned FlexW  = 11;
	localparam int unsigned IszW   = 13;
	localparam int unsigned BlkW   = 20;
	localparam int unsigned IpgW   = 20;
	localparam int unsigned TotW   = 32;
	localparam int unsigned DivW   = 37;   // 8*block_size^2 and remainder inside a group
	localparam int unsigned TailW  = 39;   // (gap + offset) * block_size
	localparam int unsigned LimW   = 31;   // inodes_per_group * flex_group_size
	localparam int unsigned ProdW  = 52;   // inodes_per_group * group
	localparam int unsigned CfgIdxW  = 8;
	localparam int unsigned CfgDataW = 32;

	localparam logic [CfgIdxW-1:0] REG_BLOCK_SIZE   = 8'd0;
	localparam logic [CfgIdxW-1:0] REG_FLEX_SIZE    = 8'd1;
	localparam logic [CfgIdxW-1:0] REG_INODE_SIZE   = 8'd2;
	localparam logic [CfgIdxW-1:0] REG_SPARSE       = 8'd3;
	localparam logic [CfgIdxW-1:0] REG_SUPER_GROWTH = 8'd4;
	localparam logic [CfgIdxW-1:0] REG_TABLE_OFFSET = 8'd5;
	localparam logic [CfgIdxW-1:0] REG_IPG          = 8'd6;
	localparam logic [CfgIdxW-1:0] REG_TOTAL        = 8'd7;

	// highest exponents whose power still fits 64 bits
	localparam int unsigned Pow3Max = 40;
	localparam int unsigned Pow5Max = 27;
	localparam int unsigned Pow7Max = 22;

	function automatic logic [63:0] ipow(input int unsigned base, input int unsigned e);
		logic [63:0] r;
		r = 64'd1;
		for (int unsigned i = 0; i < e; i++) begin
			r = r * 64'(base);
		end
		return r;
	endfunction
endpackage

/* rtl/ext4_address_to_inode_number_top.sv */
// An address passes the group divider, stages 1 to 3, the slot divider and stages 4 and 5 before its result is valid.
// Throughput: one address per cycle; a stall on m_tready freezes the whole pipe.
// Group/remainder come from an ADDR_WIDTH-stage restoring divider by 8*block_size^2,
// the inode slot from a 37-stage restoring divider by inode_size.
// Reset (arst_n low) clears all valid bits and loads the register defaults.
// Depends on e4ain_pkg and ext4_address_to_inode_number_top_assert.svh.
`include "ext4_address_to_inode_number_top_assert.svh"
module ext4_address_to_inode_number_top #(
	parameter int unsigned ADDR_WIDTH = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [((ADDR_WIDTH+7)/8)*8-1:0] s_tdata,   // byte_address
	output logic m_tvalid,
	input  logic m_tready,
	output logic [31:0] m_tdata,                        // inode_number
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [e4ain_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [e4ain_pkg::CfgDataW-1:0] cfg_data
);
	localparam int unsigned AW = ADDR_WIDTH;
	localparam int unsigned DW = e4ain_pkg::DivW;
	localparam int unsigned FW = e4ain_pkg::FlexW;
	localparam int unsigned IW = e4ain_pkg::IszW;

	// configuration registers
	logic [e4ain_pkg::BsW-1:0]   bs_q;
	logic [FW-1:0]               flex_q;
	logic [IW-1:0]               isz_q;
	logic                        sparse_q;
	logic [e4ain_pkg::BlkW-1:0]  sg_q;
	logic [e4ain_pkg::BlkW-1:0]  ito_q;
	logic [e4ain_pkg::IpgW-1:0]  ipg_q;
	logic [e4ain_pkg::TotW-1:0]  total_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q     <= 17'd4096;
			flex_q   <= 11'd16;
			isz_q    <= 13'd256;
			sparse_q <= 1'b1;
			sg_q     <= 20'd1;
			ito_q    <= 20'd33;
			ipg_q    <= 20'd8192;
			total_q  <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				e4ain_pkg::REG_BLOCK_SIZE:   bs_q     <= cfg_data[16:0];
				e4ain_pkg::REG_FLEX_SIZE:    flex_q   <= cfg_data[10:0];
				e4ain_pkg::REG_INODE_SIZE:   isz_q    <= cfg_data[12:0];
				e4ain_pkg::REG_SPARSE:       sparse_q <= cfg_data[0];
				e4ain_pkg::REG_SUPER_GROWTH: sg_q     <= cfg_data[19:0];
				e4ain_pkg::REG_TABLE_OFFSET: ito_q    <= cfg_data[19:0];
				e4ain_pkg::REG_IPG:          ipg_q    <= cfg_data[19:0];
				e4ain_pkg::REG_TOTAL:        total_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// values derived from configuration, refreshed every cycle
	logic [FW-1:0]                flex_eff;
	logic [DW-1:0]                grp_div_q;
	logic [e4ain_pkg::TailW-1:0]  tail0_q;
	logic [e4ain_pkg::TailW-1:0]  tailg_q;
	logic [e4ain_pkg::LimW-1:0]   lim_q;
	logic                         zero_q;

	assign flex_eff = (flex_q == '0) ? FW'(1) : flex_q;

	always_ff @(posedge clk) begin
		grp_div_q <= {34'(bs_q) * 34'(bs_q), 3'b000};
		tail0_q   <= e4ain_pkg::TailW'(39'(ito_q) * 39'(bs_q));
		tailg_q   <= e4ain_pkg::TailW'((39'(sg_q) + 39'(ito_q)) * 39'(bs_q));
		lim_q     <= e4ain_pkg::LimW'(31'(ipg_q) * 31'(flex_eff));
		zero_q    <= (bs_q == '0) || (isz_q == '0) || (ipg_q == '0);
	end

	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// ---- group divider: address / (8*bs^2), plus group mod flex on the quotient bits
	logic [AW-1:0] a_sh_s  [0:AW];
	logic [DW-1:0] a_rem_s [0:AW];
	logic [FW-1:0] a_mod_s [0:AW];
	logic [AW:0]   a_v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_v_s[0] <= 1'b0;
		end else if (adv) begin
			a_v_s[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_sh_s[0]  <= s_tdata[AW-1:0];
			a_rem_s[0] <= '0;
			a_mod_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < AW; k++) begin : g_div_a
		logic [DW:0] t;
		logic        ge;
		logic [DW:0] r;
		logic [FW:0] m;
		logic        mge;
		logic [FW:0] mr;
		always_comb begin
			t   = {a_rem_s[k], a_sh_s[k][AW-1]};
			ge  = t >= {1'b0, grp_div_q};
			r   = ge ? t - {1'b0, grp_div_q} : t;
			m   = {a_mod_s[k], ge};
			mge = m >= {1'b0, flex_eff};
			mr  = mge ? m - {1'b0, flex_eff} : m;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				a_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				a_v_s[k+1] <= a_v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				a_sh_s[k+1]  <= {a_sh_s[k][AW-2:0], ge};
				a_rem_s[k+1] <= r[DW-1:0];
				a_mod_s[k+1] <= mr[FW-1:0];
			end
		end
	end

	// ---- stage 1: gap selection and early kill
	logic [63:0] grp64;
	logic        pow_hit;
	logic [e4ain_pkg::Pow3Max+e4ain_pkg::Pow5Max+e4ain_pkg::Pow7Max-1:0] pow_vec;

	assign grp64 = 64'(a_sh_s[AW]);

	for (genvar e = 0; e < e4ain_pkg::Pow3Max; e++) begin : g_p3
		assign pow_vec[e] = grp64 == e4ain_pkg::ipow(3, e + 1);
	end
	for (genvar e = 0; e < e4ain_pkg::Pow5Max; e++) begin : g_p5
		assign pow_vec[e4ain_pkg::Pow3Max + e] = grp64 == e4ain_pkg::ipow(5, e + 1);
	end
	for (genvar e = 0; e < e4ain_pkg::Pow7Max; e++) begin : g_p7
		assign pow_vec[e4ain_pkg::Pow3Max + e4ain_pkg::Pow5Max + e] =
			grp64 == e4ain_pkg::ipow(7, e + 1);
	end
	assign pow_hit = |pow_vec;

	logic          v_s1, gap_s1, kill_s1;
	logic [DW-1:0] rem_s1;
	logic [31:0]   grp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= a_v_s[AW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s1  <= a_rem_s[AW];
			grp_s1  <= grp64[31:0];
			kill_s1 <= zero_q || (a_mod_s[AW] != '0) || (grp64[63:32] != '0);
			if (!sparse_q) begin
				gap_s1 <= 1'b1;
			end else if (flex_eff == FW'(1)) begin
				gap_s1 <= (grp64 <= 64'd1) || pow_hit;
			end else begin
				gap_s1 <= grp64 == 64'd0;
			end
		end
	end

	// ---- stage 2: table start inside the group, inode base product
	logic                        v_s2, kill_s2;
	logic [DW-1:0]               rem_s2;
	logic [e4ain_pkg::TailW-1:0] tail_s2;
	logic [e4ain_pkg::ProdW-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s2  <= rem_s1;
			kill_s2 <= kill_s1;
			tail_s2 <= gap_s1 ? tailg_q : tail0_q;
			prod_s2 <= e4ain_pkg::ProdW'(52'(ipg_q) * 52'(grp_s1));
		end
	end

	// ---- stage 3 feeds the slot divider: offset into the table
	logic [DW-1:0]               b_sh_s   [0:DW];
	logic [IW-1:0]               b_rem_s  [0:DW];
	logic [e4ain_pkg::ProdW-1:0] b_prod_s [0:DW];
	logic [DW:0]                 b_kill_s;
	logic [DW:0]                 b_v_s;
	logic [e4ain_pkg::TailW-1:0] off_full;

	assign off_full = e4ain_pkg::TailW'(rem_s2) - tail_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_v_s[0] <= 1'b0;
		end else if (adv) begin
			b_v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_sh_s[0]   <= off_full[DW-1:0];
			b_rem_s[0]  <= '0;
			b_prod_s[0] <= prod_s2;
			b_kill_s[0] <= kill_s2 || (e4ain_pkg::TailW'(rem_s2) < tail_s2);
		end
	end

	for (genvar k = 0; k < DW; k++) begin : g_div_b
		logic [IW:0] t;
		logic        ge;
		logic [IW:0] r;
		always_comb begin
			t  = {b_rem_s[k], b_sh_s[k][DW-1]};
			ge = t >= {1'b0, isz_q};
			r  = ge ? t - {1'b0, isz_q} : t;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				b_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				b_v_s[k+1] <= b_v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				b_sh_s[k+1]   <= {b_sh_s[k][DW-2:0], ge};
				b_rem_s[k+1]  <= r[IW-1:0];
				b_prod_s[k+1] <= b_prod_s[k];
				b_kill_s[k+1] <= b_kill_s[k];
			end
		end
	end

	// ---- stage 4: inode number and slot range check
	logic        v_s4, kill_s4;
	logic [63:0] num_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= b_v_s[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s4  <= 64'(b_sh_s[DW]) + 64'd1 + 64'(b_prod_s[DW]);
			kill_s4 <= b_kill_s[DW] || (b_sh_s[DW] >= DW'(lim_q));
		end
	end

	// ---- stage 5: output register
	logic        v_s5;
	logic [31:0] num_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s5 <= (kill_s4 || (num_s4 >= 64'(total_q))) ? 32'd0 : num_s4[31:0];
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = num_s5;

	`E4AIN_ASSERT_NEXT(a_in_enters, clk, arst_n, s_tvalid && s_tready, a_v_s[0])
	`E4AIN_ASSERT_SAME(a_below_total, clk, arst_n, m_tvalid && (m_tdata != 32'd0), m_tdata < total_q)
	`E4AIN_ASSERT_SAME(a_zero_cfg, clk, arst_n, m_tvalid && zero_q && (ipg_q == '0), m_tdata == 32'd0)
endmodule
